FILE: src/bsd_pkg.sv
package bsd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned PACK_W   = 3;

	localparam logic [3:0] BITS_FULL      = 4'd8;
	localparam logic [3:0] RUN_LEN_RESET  = 4'd4;
	localparam logic       MODE_RESET     = 1'b0;

	// register index on the config channel
	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_RUN_LEN = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIT,
		ST_STUFF,
		ST_FIN
	} state_t;

endpackage

FILE: src/bit_stuffer_destuffer.sv
// Bit stuffer / destuffer for framed byte streams.
// Input beats on s_axis carry up to eight data bits (bit 0 first) and the
// bit count; s_axis_tlast closes a frame. Output beats on m_axis carry packed
// bytes, first bit in bit 0, with the count of valid bits; m_axis_tlast marks
// the frame's final byte. A frame that ends byte-aligned with no byte in its
// last beat yields one empty beat (count 0) with tlast set.
// cfg: index 0 = mode (0 stuff, 1 destuff), index 1 = run length (reset 4).
// Write config only while the block is idle.
// Sequence: take a beat, pass the input bits and each inserted stuff bit
// through the single bit-serial datapath, see the bit count reached, then
// hand off the held byte and the flush byte; only then is the next beat
// taken, so s_axis_tready is high only between beats.
// A completed byte waits in a hold register until it is known whether it is
// the frame's final byte; a stalled m_axis_tready freezes the bit loop when a
// further byte completes, nothing is lost.
// Reset (arst_n low) clears the frame state and sets the registers to their
// reset values.
module bit_stuffer_destuffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] in_byte, [11:8] in_bits, [15:12] zero
	input  logic        s_axis_tlast,   // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] out_bits, [15:12] zero
	output logic        m_axis_tlast,   // out_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import bsd_pkg::*;

	state_t state_q, state_d;

	logic        mode_q;
	logic [3:0]  run_len_q;

	logic [7:0]  byte_q;
	logic [3:0]  nb_q;
	logic        last_q;
	logic [3:0]  idx_q;

	logic [3:0]  run_count_q;
	logic        prev_bit_q;
	logic        prev_valid_q;
	logic        drop_pending_q;
	logic [7:0]  pack_shift_q;
	logic [2:0]  pack_count_q;

	logic [7:0]  hold_q;
	logic        hold_valid_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [3:0]  out_bits_q;
	logic        out_last_q;

	logic        s_acc;
	logic        out_free;
	logic [3:0]  rl_eff;
	logic        cur_bit;
	logic        done_bits;
	logic        brk;
	logic [3:0]  rc_new;
	logic        run_hit;
	logic        put_val;
	logic        byte_full;
	logic [7:0]  new_shift;
	logic        put_stall;

	// control strobes
	logic        put_en;
	logic        drop_en;
	logic        bit_en;
	logic        stuff_en;
	logic        fin_hold;
	logic        fin_flush;
	logic        frame_clr;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign rl_eff    = (run_len_q == 4'd0) ? 4'd1 : run_len_q;
	assign cur_bit   = byte_q[idx_q[2:0]];
	assign done_bits = (idx_q == nb_q);
	assign brk       = last_q && mode_q && prev_valid_q && (pack_count_q == 3'd0);
	assign rc_new    = (prev_valid_q && (cur_bit == prev_bit_q)) ? run_count_q + 4'd1 : 4'd1;
	assign run_hit   = (rc_new >= rl_eff);
	assign put_val   = (state_q == ST_STUFF) ? ~prev_bit_q : cur_bit;
	assign byte_full = (pack_count_q == 3'd7);
	assign new_shift = pack_shift_q | (8'(put_val) << pack_count_q);
	assign put_stall = byte_full && hold_valid_q && !out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) state_d = ST_BIT;
			end
			ST_BIT: begin
				priority if (done_bits || brk) state_d = ST_FIN;
				else if (mode_q && drop_pending_q) state_d = ST_BIT;
				else if (put_stall) state_d = ST_BIT;
				else if (run_hit && !mode_q) state_d = ST_STUFF;
				else state_d = ST_BIT;
			end
			ST_STUFF: begin
				if (!put_stall) state_d = ST_BIT;
			end
			ST_FIN: begin
				priority if (hold_valid_q) begin
					if (out_free)
						state_d = (last_q && pack_count_q != 3'd0) ? ST_FIN : ST_IDLE;
				end else if (!last_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath strobes
	always_comb begin
		put_en    = 1'b0;
		drop_en   = 1'b0;
		bit_en    = 1'b0;
		stuff_en  = 1'b0;
		fin_hold  = 1'b0;
		fin_flush = 1'b0;
		frame_clr = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_BIT: begin
				if (!(done_bits || brk)) begin
					if (mode_q && drop_pending_q) begin
						drop_en = 1'b1;
					end else if (!put_stall) begin
						put_en = 1'b1;
						bit_en = 1'b1;
					end
				end
			end
			ST_STUFF: begin
				if (!put_stall) begin
					put_en   = 1'b1;
					stuff_en = 1'b1;
				end
			end
			ST_FIN: begin
				if (hold_valid_q) begin
					fin_hold  = out_free;
					frame_clr = out_free && last_q && (pack_count_q == 3'd0);
				end else if (last_q) begin
					fin_flush = out_free;
					frame_clr = out_free;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mode_q         <= MODE_RESET;
			run_len_q      <= RUN_LEN_RESET;
			idx_q          <= 4'd0;
			run_count_q    <= 4'd0;
			prev_bit_q     <= 1'b0;
			prev_valid_q   <= 1'b0;
			drop_pending_q <= 1'b0;
			pack_shift_q   <= 8'd0;
			pack_count_q   <= 3'd0;
			hold_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MODE:    mode_q    <= cfg_data[0];
					REG_RUN_LEN: run_len_q <= cfg_data;
					default: ;
				endcase
			end

			if (s_acc) idx_q <= 4'd0;
			else if (bit_en || drop_en) idx_q <= idx_q + 4'd1;

			if (drop_en) begin
				drop_pending_q <= 1'b0;
				prev_bit_q     <= cur_bit;
				prev_valid_q   <= 1'b1;
				run_count_q    <= 4'd1;
			end

			if (bit_en) begin
				prev_bit_q   <= cur_bit;
				prev_valid_q <= 1'b1;
				run_count_q  <= (run_hit && mode_q) ? 4'd0 : rc_new;
				if (run_hit && mode_q)
					drop_pending_q <= 1'b1;
			end

			if (stuff_en) begin
				prev_bit_q  <= ~prev_bit_q;
				run_count_q <= 4'd1;
			end

			if (put_en) begin
				if (byte_full) begin
					pack_shift_q <= 8'd0;
					pack_count_q <= 3'd0;
					hold_valid_q <= 1'b1;
				end else begin
					pack_shift_q <= new_shift;
					pack_count_q <= pack_count_q + 3'd1;
				end
			end

			if (fin_hold) hold_valid_q <= 1'b0;

			if ((put_en && byte_full && hold_valid_q) || fin_hold || fin_flush)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			if (frame_clr) begin
				run_count_q    <= 4'd0;
				prev_bit_q     <= 1'b0;
				prev_valid_q   <= 1'b0;
				drop_pending_q <= 1'b0;
				pack_shift_q   <= 8'd0;
				pack_count_q   <= 3'd0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			byte_q <= s_axis_tdata[7:0];
			nb_q   <= (s_axis_tdata[11:8] > BITS_FULL) ? BITS_FULL : s_axis_tdata[11:8];
			last_q <= s_axis_tlast;
		end
		if (put_en && byte_full) hold_q <= new_shift;
		if ((put_en && byte_full && hold_valid_q) || fin_hold) begin
			out_byte_q <= hold_q;
			out_bits_q <= BITS_FULL;
			out_last_q <= fin_hold && last_q && (pack_count_q == 3'd0);
		end else if (fin_flush) begin
			out_byte_q <= (pack_count_q != 3'd0) ? pack_shift_q : 8'd0;
			out_bits_q <= {1'b0, pack_count_q};
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_bits_q, out_byte_q};
	assign m_axis_tlast  = out_last_q;

	// a held byte never outlives its input beat
	a_hold_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_valid_q)
		else $error("hold byte left over while idle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIT) |-> (idx_q <= nb_q))
		else $error("bit index past bit count");

	a_stuff_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STUFF) |-> !mode_q)
		else $error("stuff bit in destuff mode");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_bits_q == 4'd0) |-> out_last_q)
		else $error("empty beat without tlast");

	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		frame_clr |=> (pack_count_q == 3'd0 && !prev_valid_q && !drop_pending_q))
		else $error("frame state not cleared");

endmodule

FILE: verif/bit_stuffer_destuffer_tb.sv
`timescale 1ns / 1ps

module bit_stuffer_destuffer_tb;
	import bsd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] nbits;
		logic       last;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_MODE;
	logic [3:0]  cfg_data = '0;

	bit_stuffer_destuffer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// register copies and frame state of the coder
	logic       mode_cfg = MODE_RESET;
	logic [3:0] run_len_cfg = RUN_LEN_RESET;
	int         run_cnt = 0;
	bit         last_bit = 1'b0;
	bit         seen_bit = 1'b0;
	bit         drop_next = 1'b0;
	logic [7:0] shreg = '0;
	int         fill = 0;

	beat_t beats_to_send[$];
	beat_t bytes_due[$];
	beat_t cur_beat = '0;
	bit    offering = 1'b0;

	int beats_queued = 0;
	int beats_taken = 0;
	int frames_taken = 0;
	int bytes_seen = 0;
	int reg_writes = 0;
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;

	task automatic pack_bit(input bit bv, inout int n_out);
		shreg[fill] = bv;
		fill++;
		if (fill == 8) begin
			bytes_due.push_back('{data: shreg, nbits: BITS_FULL, last: 1'b0});
			n_out++;
			shreg = '0;
			fill = 0;
		end
	endtask

	task automatic recode_beat(input beat_t b);
		int nb;
		int rl;
		int n_out;
		bit bv;
		rl = (run_len_cfg < 1) ? 1 : int'(run_len_cfg);
		nb = (b.nbits > 8) ? 8 : int'(b.nbits);
		n_out = 0;
		for (int i = 0; i < nb; i++) begin
			bv = b.data[i];
			// destuff tail: rest of the last beat is padding once aligned
			if (b.last && mode_cfg && seen_bit && fill == 0)
				break;
			if (mode_cfg && drop_next) begin
				drop_next = 1'b0;
				last_bit = bv;
				seen_bit = 1'b1;
				run_cnt = 1;
				continue;
			end
			if (seen_bit && bv == last_bit)
				run_cnt++;
			else
				run_cnt = 1;
			last_bit = bv;
			seen_bit = 1'b1;
			pack_bit(bv, n_out);
			if (run_cnt >= rl) begin
				if (!mode_cfg) begin
					pack_bit(~bv, n_out);
					last_bit = ~bv;
					run_cnt = 1;
				end else begin
					drop_next = 1'b1;
					run_cnt = 0;
				end
			end
		end
		if (b.last) begin
			if (fill > 0)
				bytes_due.push_back('{data: shreg, nbits: 4'(fill), last: 1'b1});
			else if (n_out > 0)
				bytes_due[$].last = 1'b1;
			else
				bytes_due.push_back('{data: 8'h00, nbits: 4'd0, last: 1'b1});
			run_cnt = 0;
			last_bit = 1'b0;
			seen_bit = 1'b0;
			drop_next = 1'b0;
			shreg = '0;
			fill = 0;
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				recode_beat(cur_beat);
				beats_taken++;
				if (cur_beat.last)
					frames_taken++;
				offering = 1'b0;
			end
			if (!offering && beats_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
				cur_beat = beats_to_send.pop_front();
				offering = 1'b1;
			end
			s_axis_tvalid <= offering;
			s_axis_tdata <= {4'b0, cur_beat.nbits, cur_beat.data};
			s_axis_tlast <= cur_beat.last;
		end
	end

	// receiver backpressure, with an occasional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_reqs != hold_served) begin
			hold_served++;
			hold_left = 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// output checker
	always @(posedge clk) begin
		beat_t exp_b;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			bytes_seen++;
			if (bytes_due.size() == 0) begin
				$error("unexpected output beat: byte %h bits %0d last %0b",
					m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tlast);
				errors++;
			end else begin
				exp_b = bytes_due.pop_front();
				if (m_axis_tdata[7:0] !== exp_b.data) begin
					$error("out_byte: expected %h, got %h", exp_b.data, m_axis_tdata[7:0]);
					errors++;
				end
				if (m_axis_tdata[11:8] !== exp_b.nbits) begin
					$error("out_bits: expected %0d, got %0d", exp_b.nbits, m_axis_tdata[11:8]);
					errors++;
				end
				if (m_axis_tlast !== exp_b.last) begin
					$error("out_last: expected %0b, got %0b", exp_b.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	task automatic offer(input logic [7:0] data, input logic [3:0] nbits, input logic last);
		beats_to_send.push_back('{data: data, nbits: nbits, last: last});
		beats_queued++;
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MODE)
			mode_cfg = val[0];
		else
			run_len_cfg = val;
		reg_writes++;
	endtask

	// drain everything, then leave room for a beat that yields no byte
	task automatic settle();
		while (beats_taken != beats_queued || bytes_due.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic queue_frame(input int nbeats);
		logic [7:0] d;
		logic [3:0] nb;
		int r;
		for (int k = 0; k < nbeats; k++) begin
			r = $urandom_range(99);
			// long runs of equal bits are what trigger stuffing
			d = (r < 35) ? {8{1'($urandom_range(1))}} : 8'($urandom_range(255));
			r = $urandom_range(99);
			if (r < 3)
				nb = 4'd0;
			else if (r < 7)
				nb = 4'($urandom_range(15, 9));
			else if (r < 55)
				nb = 4'd8;
			else
				nb = 4'($urandom_range(7, 1));
			offer(d, nb, k == nbeats - 1);
		end
	endtask

	initial begin
		int chunk_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 26;
		stall_pct = 26;

		// reset settings: stuffing, run length 4
		offer(8'h00, 4'd8, 1'b1);
		offer(8'hFF, 4'd8, 1'b1);
		offer(8'h55, 4'd8, 1'b1);   // ends aligned on a full byte
		offer(8'hA5, 4'd8, 1'b0);
		offer(8'h00, 4'd0, 1'b1);   // empty last beat -> empty flush beat
		offer(8'hFF, 4'd15, 1'b0);  // oversized bit counts clamp to 8
		offer(8'h3C, 4'd9, 1'b0);
		offer(8'h01, 4'd1, 1'b1);
		offer(8'h00, 4'd8, 1'b0);
		settle();
		write_reg(REG_MODE, 4'd1);  // switch mode inside a frame
		offer(8'h00, 4'd8, 1'b1);
		settle();
		write_reg(REG_RUN_LEN, 4'd1);
		offer(8'hFF, 4'd8, 1'b0);
		offer(8'h00, 4'd8, 1'b1);
		settle();
		write_reg(REG_MODE, 4'd0);
		write_reg(REG_RUN_LEN, 4'd0);
		offer(8'h96, 4'd8, 1'b1);
		settle();
		write_reg(REG_MODE, 4'd1);
		write_reg(REG_RUN_LEN, 4'd4);
		offer(8'h55, 4'd8, 1'b0);
		offer(8'hFF, 4'd8, 1'b1);   // aligned: whole last beat is dropped
		offer(8'h0F, 4'd4, 1'b1);   // drop still pending at frame end
		offer(8'h80, 4'd8, 1'b1);
		settle();

		for (int c = 0; c < 8; c++) begin
			case (c / 2)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 87; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 87; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			if (c < 4) begin
				write_reg(REG_MODE, 4'(c % 2));
				write_reg(REG_RUN_LEN, (c < 2) ? 4'd2 : 4'd15);
			end else begin
				write_reg(REG_MODE, 4'($urandom_range(1)));
				write_reg(REG_RUN_LEN, 4'($urandom_range(15, 2)));
			end
			if (c == 0)
				hold_reqs++;        // output stalls while input keeps coming
			chunk_start = beats_queued;
			while (beats_queued - chunk_start < 34)
				queue_frame($urandom_range(6, 1));
			settle();
		end

		$display("coded %0d frames (%0d beats in, %0d beats out) over %0d register writes",
			frames_taken, beats_taken, bytes_seen, reg_writes);
		$display("both modes, run lengths 0..15, clamped and empty bit counts, four flow phases");
		if (errors == 0)
			$display("bit_stuffer_destuffer: match");
		else
			$display("bit_stuffer_destuffer: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout: %0d beats waiting, %0d results outstanding",
			beats_to_send.size(), bytes_due.size());
		$display("bit_stuffer_destuffer: mismatch");
		$finish;
	end

endmodule
